FILE: design/hrf_pkg.sv
package hrf_pkg;

	localparam int BUCKETS_DEF = 1024;
	localparam int WAYS_DEF    = 4;

	localparam int ID_W     = 32;
	localparam int TIME_W   = 32;
	localparam int WIN_W    = 16;
	localparam int KEY_W    = ID_W + 1;
	localparam int S_DATA_W = ID_W + TIME_W;
	localparam int M_DATA_W = 8;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd5;

	localparam logic REG_WINDOW = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} ctrl_state_t;

	typedef struct packed {
		logic recent;
		logic not_stored;
		logic write;
	} match_res_t;

endpackage

FILE: design/hrf_cfg_regs.sv
module hrf_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hrf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [hrf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [hrf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [hrf_pkg::WIN_W-1:0]        window
);
	import hrf_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign window  = window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && (reg_sel == REG_WINDOW)) begin
			window_q <= pwdata[WIN_W-1:0];
		end
	end

	always_comb begin
		if (reg_sel == REG_WINDOW) begin
			prdata = {{(APB_DATA_W-WIN_W){1'b0}}, window_q};
		end else begin
			prdata = '0;
		end
	end

endmodule

FILE: design/hrf_bucket_store.sv
module hrf_bucket_store #(
	parameter int BUCKETS = hrf_pkg::BUCKETS_DEF,
	parameter int WAYS    = hrf_pkg::WAYS_DEF,
	localparam int BIDX_W = $clog2(BUCKETS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [BIDX_W-1:0]                   rd_addr,
	output logic [WAYS*hrf_pkg::KEY_W-1:0]      key_rd,
	output logic [WAYS*hrf_pkg::TIME_W-1:0]     stamp_rd,
	input  logic                                wr_en,
	input  logic [BIDX_W-1:0]                   wr_addr,
	input  logic [WAYS*hrf_pkg::KEY_W-1:0]      key_wr,
	input  logic [WAYS*hrf_pkg::TIME_W-1:0]     stamp_wr,
	output logic                                busy
);
	import hrf_pkg::*;

	logic [WAYS*KEY_W-1:0]  key_mem   [BUCKETS];
	logic [WAYS*TIME_W-1:0] stamp_mem [BUCKETS];

	logic [WAYS*KEY_W-1:0]  key_rd_q;
	logic [WAYS*TIME_W-1:0] stamp_rd_q;

	logic              clearing_q;
	logic [BIDX_W:0]   clr_cnt_q;

	logic              key_we;
	logic [BIDX_W-1:0] key_waddr;
	logic [WAYS*KEY_W-1:0] key_wdata;

	assign busy     = clearing_q;
	assign key_rd   = key_rd_q;
	assign stamp_rd = stamp_rd_q;

	// The key rows hold the valid bits, so a sweep after reset zeroes them row by row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (BIDX_W+1)'(BUCKETS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			key_we    = 1'b1;
			key_waddr = clr_cnt_q[BIDX_W-1:0];
			key_wdata = '0;
		end else begin
			key_we    = wr_en;
			key_waddr = wr_addr;
			key_wdata = key_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !clearing_q) begin
			stamp_mem[wr_addr] <= stamp_wr;
		end
		if (rd_en) begin
			stamp_rd_q <= stamp_mem[rd_addr];
		end
	end

endmodule

FILE: design/hrf_way_match.sv
module hrf_way_match #(
	parameter int WAYS = hrf_pkg::WAYS_DEF
) (
	input  logic [WAYS*hrf_pkg::KEY_W-1:0]   key_row,
	input  logic [WAYS*hrf_pkg::TIME_W-1:0]  stamp_row,
	input  logic [hrf_pkg::ID_W-1:0]         ident,
	input  logic [hrf_pkg::TIME_W-1:0]       now_seconds,
	input  logic [hrf_pkg::WIN_W-1:0]        window,
	output hrf_pkg::match_res_t              res,
	output logic [WAYS*hrf_pkg::KEY_W-1:0]   key_new,
	output logic [WAYS*hrf_pkg::TIME_W-1:0]  stamp_new
);
	import hrf_pkg::*;

	localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic              hit;
	logic              free_found;
	logic [WIDX_W-1:0] hit_way;
	logic [WIDX_W-1:0] free_way;
	logic [TIME_W-1:0] age;
	logic              is_recent;

	always_comb begin
		hit        = 1'b0;
		free_found = 1'b0;
		hit_way    = '0;
		free_way   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (key_row[w*KEY_W + ID_W]) begin
				if (!hit && (key_row[w*KEY_W +: ID_W] == ident)) begin
					hit     = 1'b1;
					hit_way = WIDX_W'(w);
				end
			end else if (!free_found) begin
				free_found = 1'b1;
				free_way   = WIDX_W'(w);
			end
		end
	end

	assign age       = now_seconds - stamp_row[hit_way*TIME_W +: TIME_W];
	assign is_recent = hit && (age < {{(TIME_W-WIN_W){1'b0}}, window});

	always_comb begin
		key_new   = key_row;
		stamp_new = stamp_row;
		if (hit) begin
			stamp_new[hit_way*TIME_W +: TIME_W] = now_seconds;
		end else begin
			key_new[free_way*KEY_W +: KEY_W]     = {1'b1, ident};
			stamp_new[free_way*TIME_W +: TIME_W] = now_seconds;
		end
	end

	assign res.recent     = is_recent;
	assign res.not_stored = !hit && !free_found;
	assign res.write      = hit ? !is_recent : free_found;

endmodule

FILE: design/hashed_recent_id_filter_unit.sv
// Recent identifier filter. Each beat on the slave stream carries an identifier and the
// current time in seconds; each produces exactly one result beat on the master stream
// telling whether the identifier was seen within window_seconds, and whether a miss
// found its bucket full so that nothing was recorded.
// The identifier's low bits select a bucket of WAYS entries in a synchronous memory.
// An accepted beat starts the bucket read; once the output register is free, the ways
// are compared, the row is written back if needed and the result is loaded into the
// output register. The block takes no new beat until the last one's lookup is done, as
// each bucket row sees one read and one write-back. BUCKETS must be a power of two.
// After reset the block sweeps the key memory to clear every valid bit; s_tready stays
// low during the sweep, while the APB port works as ever. When the receiver stalls, a
// new beat is still accepted while a result waits; its lookup then holds until the
// output register is free, and s_tready stays low. window_seconds is written through
// the APB port at address 0; the user must write it only while the block is idle, as
// the block does not enforce this.
module hashed_recent_id_filter_unit #(
	parameter int BUCKETS = hrf_pkg::BUCKETS_DEF,
	parameter int WAYS    = hrf_pkg::WAYS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [hrf_pkg::S_DATA_W-1:0]     s_tdata,   // ident, now_seconds
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [hrf_pkg::M_DATA_W-1:0]     m_tdata,   // recent, not_stored, zero fill
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hrf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [hrf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [hrf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import hrf_pkg::*;

	localparam int BIDX_W = $clog2(BUCKETS);

	ctrl_state_t state_q, state_d;

	logic [ID_W-1:0]   ident_s1;
	logic [TIME_W-1:0] now_s1;
	logic [BIDX_W-1:0] bucket_s1;

	logic              out_valid_q;
	logic              recent_q;
	logic              not_stored_q;

	logic [WIN_W-1:0]        window;
	logic                    busy;
	logic                    in_accept;
	logic                    finish;
	logic [WAYS*KEY_W-1:0]   key_rd;
	logic [WAYS*TIME_W-1:0]  stamp_rd;
	logic [WAYS*KEY_W-1:0]   key_new;
	logic [WAYS*TIME_W-1:0]  stamp_new;
	match_res_t              res;

	hrf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.window  (window)
	);

	hrf_bucket_store #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_accept),
		.rd_addr  (s_tdata[BIDX_W-1:0]),
		.key_rd   (key_rd),
		.stamp_rd (stamp_rd),
		.wr_en    (finish && res.write),
		.wr_addr  (bucket_s1),
		.key_wr   (key_new),
		.stamp_wr (stamp_new),
		.busy     (busy)
	);

	hrf_way_match #(
		.WAYS (WAYS)
	) u_match (
		.key_row     (key_rd),
		.stamp_row   (stamp_rd),
		.ident       (ident_s1),
		.now_seconds (now_s1),
		.window      (window),
		.res         (res),
		.key_new     (key_new),
		.stamp_new   (stamp_new)
	);

	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !busy;
				if (s_tvalid && !busy) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!out_valid_q || m_tready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ident_s1  <= s_tdata[ID_W-1:0];
			now_s1    <= s_tdata[ID_W +: TIME_W];
			bucket_s1 <= s_tdata[BIDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			recent_q     <= res.recent;
			not_stored_q <= res.not_stored;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W-2){1'b0}}, not_stored_q, recent_q};

endmodule

FILE: design/hrf_checker.sv
module hrf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hrf_pkg::M_DATA_W-1:0]  m_tdata
);
	import hrf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted in back-to-back cycles");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("recent and not_stored both set");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
		else $error("result missing two cycles after acceptance");

endmodule

bind hashed_recent_id_filter_unit hrf_checker u_hrf_checker (.*);

FILE: tb/tb_hashed_recent_id_filter_unit.sv
`timescale 1ns / 100ps

module tb_hashed_recent_id_filter_unit;
	import hrf_pkg::*;

	localparam int BUCKETS      = BUCKETS_DEF;
	localparam int WAYS         = WAYS_DEF;
	localparam int ENTRIES      = BUCKETS * WAYS;
	localparam int IDLE_LIMIT   = 20000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic recent;
		logic not_stored;
	} verdict_t;

	class recent_id_scoreboard;
		bit               key_valid [ENTRIES];
		logic [ID_W-1:0]  key_id    [ENTRIES];
		logic [TIME_W-1:0] stamp    [ENTRIES];
		logic [WIN_W-1:0] window;
		verdict_t         pending[$];
		int               errors;
		int               n_checked;
		int               n_recent;
		int               n_full;

		function new();
			foreach (key_valid[i]) key_valid[i] = 1'b0;
			window = WINDOW_RESET;
			errors = 0;
			n_checked = 0;
			n_recent = 0;
			n_full = 0;
		endfunction

		function void set_window(logic [WIN_W-1:0] value);
			window = value;
		endfunction

		function void note_input(logic [ID_W-1:0] ident, logic [TIME_W-1:0] now);
			int base;
			int slot;
			int free_slot;
			bit have_free;
			bit done;
			logic [TIME_W-1:0] age;
			verdict_t v;
			base = int'(ident % 32'(BUCKETS)) * WAYS;
			free_slot = 0;
			have_free = 1'b0;
			done = 1'b0;
			v = '0;
			for (int w = 0; w < WAYS && !done; w++) begin
				slot = base + w;
				if (key_valid[slot]) begin
					if (key_id[slot] == ident) begin
						done = 1'b1;
						age = now - stamp[slot];
						if (age < {16'd0, window}) begin
							v.recent = 1'b1;
						end else begin
							stamp[slot] = now;
						end
					end
				end else if (!have_free) begin
					have_free = 1'b1;
					free_slot = slot;
				end
			end
			if (!done) begin
				if (have_free) begin
					key_valid[free_slot] = 1'b1;
					key_id[free_slot] = ident;
					stamp[free_slot] = now;
				end else begin
					v.not_stored = 1'b1;
				end
			end
			pending.push_back(v);
		endfunction

		function void check_result(logic recent, logic not_stored);
			verdict_t v;
			if (pending.size() == 0) begin
				$error("result beat with no pending expectation: recent %0b not_stored %0b",
					recent, not_stored);
				errors++;
				return;
			end
			v = pending.pop_front();
			n_checked++;
			if (v.recent) n_recent++;
			if (v.not_stored) n_full++;
			if (recent !== v.recent) begin
				$error("recent: expected %0b, got %0b", v.recent, recent);
				errors++;
			end
			if (not_stored !== v.not_stored) begin
				$error("not_stored: expected %0b, got %0b", v.not_stored, not_stored);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;     // ident, now_seconds
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;          // recent, not_stored, zero fill
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	recent_id_scoreboard sb = new();

	bit              stall_en = 1'b1;
	bit              hold_req = 1'b0;
	int              idle_cycles = 0;
	logic [TIME_W-1:0] clock_now = '0;

	hashed_recent_id_filter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_input(s_tdata[ID_W-1:0], s_tdata[S_DATA_W-1:ID_W]);
		end
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata[0], m_tdata[1]);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_en && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic send(logic [ID_W-1:0] ident, logic [TIME_W-1:0] now);
		int gap;
		gap = (stall_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now, ident};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (int'(addr >> 2) == int'(REG_WINDOW)) sb.set_window(data[WIN_W-1:0]);
		@(posedge clk);
	endtask

	task automatic apb_check(logic [APB_ADDR_W-1:0] addr);
		logic [APB_DATA_W-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = {{(APB_DATA_W-WIN_W){1'b0}}, sb.window};
		if (prdata !== want) begin
			$error("window_seconds: expected %0d, got %0d", want, prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int count, bit pressure);
		logic [ID_W-1:0] pool [48];
		int              hot [8];
		logic [ID_W-1:0] tmp;
		logic [ID_W-1:0] ident;
		logic [TIME_W-1:0] now;
		int              r;
		foreach (hot[i]) hot[i] = $urandom_range(0, BUCKETS - 1);
		foreach (pool[i]) begin
			tmp = $urandom();
			pool[i] = tmp - (tmp % 32'(BUCKETS)) + 32'(hot[$urandom_range(0, 7)]);
		end
		for (int n = 0; n < count; n++) begin
			if (pressure && n == count / 2) hold_req = 1'b1;
			r = $urandom_range(0, 9);
			if (r < 8) begin
				ident = pool[$urandom_range(0, 47)];
				if ($urandom_range(0, 15) == 0) begin
					clock_now = clock_now + $urandom_range(0, 70000);
				end else begin
					clock_now = clock_now + $urandom_range(0, 3);
				end
				now = clock_now;
			end else if (r == 8) begin
				ident = $urandom();
				now = $urandom();
			end else begin
				ident = pool[$urandom_range(0, 47)];
				now = ($urandom_range(0, 1) == 0) ? $urandom() : clock_now - $urandom_range(1, 8);
			end
			send(ident, now);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window is five seconds.
		send(32'h0000_0000, 32'd0);
		send(32'h0000_0000, 32'd4);
		send(32'h0000_0000, 32'd5);
		send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(32'hFFFF_FFFF, 32'd2);
		send(32'h0000_0000, 32'd3);
		for (int k = 0; k < 5; k++) send(32'd7 + 32'(k * BUCKETS), 32'd100);
		send(32'd7 + 32'(4 * BUCKETS), 32'd101);
		send(32'd7 + 32'(2 * BUCKETS), 32'd102);
		send(32'h8000_0000, 32'h8000_0000);
		send(32'hAAAA_AAAA, 32'h5555_5555);
		send(32'h5555_5555, 32'hAAAA_AAAA);
		drain();

		apb_write(3'd0, 32'd0);
		apb_check(3'd0);
		send(32'h0000_0000, 32'd3);
		send(32'h0000_0000, 32'd3);
		send(32'h8000_0000, 32'h8000_0001);
		drain();

		apb_write(3'd0, 32'd65535);
		clock_now = 32'hFFFF_FE00;
		run_random(350, 1'b0);
		drain();

		apb_write(3'd4, 32'h0000_1234);
		apb_check(3'd0);
		apb_write(3'd0, 32'd1);
		run_random(350, 1'b1);
		drain();

		apb_write(3'd0, 32'($urandom_range(2, 40)));
		apb_check(3'd0);
		run_random(500, 1'b0);
		drain();

		apb_write(3'd0, 32'd5);
		stall_en = 1'b0;
		run_random(700, 1'b0);
		drain();

		$display("Checked %0d result beats: %0d recent, %0d with the bucket full.",
			sb.n_checked, sb.n_recent, sb.n_full);
		$display("Windows 0, 1, 5, 65535 and random, stalls, a long output hold-off, time wrap.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
